[src/bpc_pkg.sv]
package bpc_pkg;

    localparam int DIV_STEPS = 32;
    localparam int LATENCY   = 2 + DIV_STEPS + 1 + 4 + DIV_STEPS + 3;

    localparam logic [1:0] REG_CAL_A = 2'd0;
    localparam logic [1:0] REG_CAL_B = 2'd1;
    localparam logic [1:0] REG_CAL_C = 2'd2;
    localparam logic [1:0] REG_OSS   = 2'd3;

    localparam logic [31:0] K_B6_OFS   = 32'd4000;
    localparam logic [31:0] K_B4_OFS   = 32'd32768;
    localparam logic [31:0] K_B7_SCALE = 32'd50000;
    localparam logic [31:0] K_P_SQ     = 32'd3038;
    localparam logic [31:0] K_P_LIN    = 32'hFFFF_E343;
    localparam logic [31:0] K_P_OFS    = 32'd3791;
    localparam logic [31:0] K_T_RND    = 32'd8;

    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [23:0] raw_pressure;
    } t_in;

    typedef struct packed {
        logic signed [31:0] temperature_tenths;
        logic signed [31:0] pressure_pa;
        logic               divide_fault;
    } t_out;

    typedef struct packed {
        logic [31:0] ac1;
        logic [31:0] ac2;
        logic [31:0] ac3;
        logic [31:0] ac4;
        logic [31:0] ac5;
        logic [31:0] ac6;
        logic [31:0] b1;
        logic [31:0] b2;
        logic [31:0] mc;
        logic [31:0] md;
        logic [1:0]  oss;
    } t_cal;

    typedef struct packed {
        logic        fault;
        logic        neg;
        logic        dbl;
        logic [31:0] x1;
        logic [31:0] temp;
        logic [31:0] up;
    } t_ctx;

    typedef struct packed {
        logic        fault;
        logic [31:0] temp;
        logic [31:0] b6;
        logic [31:0] up;
    } t_mid;

    function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] s);
        return 32'($signed(v) >>> s);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

[src/bpc_div.sv]
module bpc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  logic [31:0]        i_dividend,
    input  logic [31:0]        i_divisor,
    input  bpc_pkg::t_ctx      i_ctx,
    output logic               o_vld,
    output logic [31:0]        o_quo,
    output bpc_pkg::t_ctx      o_ctx
);

    localparam int N = bpc_pkg::DIV_STEPS;

    logic          r_vld [N];
    logic [31:0]   r_rem [N];
    logic [31:0]   r_quo [N];
    logic [31:0]   r_dvs [N];
    bpc_pkg::t_ctx r_ctx [N];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_step
            logic          vld_in;
            logic [31:0]   rem_in;
            logic [31:0]   quo_in;
            logic [31:0]   dvs_in;
            bpc_pkg::t_ctx ctx_in;
            logic [32:0]   trial;
            logic [32:0]   diff;
            logic          ge;

            if (k == 0) begin : g_first
                assign vld_in = i_vld;
                assign rem_in = '0;
                assign quo_in = i_dividend;
                assign dvs_in = i_divisor;
                assign ctx_in = i_ctx;
            end else begin : g_next
                assign vld_in = r_vld[k-1];
                assign rem_in = r_rem[k-1];
                assign quo_in = r_quo[k-1];
                assign dvs_in = r_dvs[k-1];
                assign ctx_in = r_ctx[k-1];
            end

            assign trial = {rem_in, quo_in[31]};
            assign diff  = trial - {1'b0, dvs_in};
            assign ge    = trial >= {1'b0, dvs_in};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else begin
                    r_vld[k] <= vld_in;
                end
            end

            always_ff @(posedge i_clk) begin
                r_rem[k] <= ge ? diff[31:0] : trial[31:0];
                r_quo[k] <= {quo_in[30:0], ge};
                r_dvs[k] <= dvs_in;
                r_ctx[k] <= ctx_in;
            end
        end
    endgenerate

    assign o_vld = r_vld[N-1];
    assign o_quo = r_quo[N-1];
    assign o_ctx = r_ctx[N-1];

endmodule

[src/bpc_temp.sv]
module bpc_temp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  bpc_pkg::t_in  i_in,
    input  bpc_pkg::t_cal i_cal,
    output logic          o_vld,
    output bpc_pkg::t_mid o_mid
);

    logic          r_vld_a;
    logic [31:0]   r_ut;
    logic [31:0]   r_up;
    logic          r_vld_t;
    logic [31:0]   r_x1;
    logic [31:0]   r_den;
    logic [31:0]   r_upt;
    logic [3:0]    shamt;
    logic [31:0]   n_x1;
    logic [31:0]   num;
    logic [31:0]   ma;
    logic [31:0]   mb;
    bpc_pkg::t_ctx dctx;
    logic          q_vld;
    logic [31:0]   q;
    bpc_pkg::t_ctx q_ctx;
    logic [31:0]   x2;
    logic [31:0]   b5;
    logic          r_vld_o;
    bpc_pkg::t_mid r_mid;

    assign shamt = 4'd8 - {2'b00, i_cal.oss};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_t <= 1'b0;
            r_vld_o <= 1'b0;
        end else begin
            r_vld_a <= i_vld;
            r_vld_t <= r_vld_a;
            r_vld_o <= q_vld;
        end
    end

    assign n_x1 = bpc_pkg::asr32((r_ut - i_cal.ac6) * i_cal.ac5, 5'd15);

    always_ff @(posedge i_clk) begin
        r_ut  <= {16'd0, i_in.raw_temperature};
        r_up  <= {8'd0, i_in.raw_pressure >> shamt};
        r_x1  <= n_x1;
        r_den <= n_x1 + i_cal.md;
        r_upt <= r_up;
    end

    // signed divide through magnitudes
    assign num  = i_cal.mc << 11;
    assign ma   = num[31] ? 32'd0 - num : num;
    assign mb   = r_den[31] ? 32'd0 - r_den : r_den;
    always_comb begin
        dctx       = '0;
        dctx.fault = (r_den == 32'd0);
        dctx.neg   = num[31] ^ r_den[31];
        dctx.x1    = r_x1;
        dctx.up    = r_upt;
    end

    bpc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (r_vld_t),
        .i_dividend (ma),
        .i_divisor  (mb),
        .i_ctx      (dctx),
        .o_vld      (q_vld),
        .o_quo      (q),
        .o_ctx      (q_ctx)
    );

    assign x2 = q_ctx.neg ? 32'd0 - q : q;
    assign b5 = q_ctx.x1 + x2;

    always_ff @(posedge i_clk) begin
        r_mid.fault <= q_ctx.fault;
        r_mid.temp  <= bpc_pkg::asr32(b5 + bpc_pkg::K_T_RND, 5'd4);
        r_mid.b6    <= b5 - bpc_pkg::K_B6_OFS;
        r_mid.up    <= q_ctx.up;
    end

    assign o_vld = r_vld_o;
    assign o_mid = r_mid;

endmodule

[src/bpc_press.sv]
module bpc_press (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  bpc_pkg::t_mid i_mid,
    input  bpc_pkg::t_cal i_cal,
    output logic          o_vld,
    output bpc_pkg::t_out o_out
);

    logic [3:0]    r_vld;
    bpc_pkg::t_mid r_m1;
    bpc_pkg::t_mid r_m2;
    bpc_pkg::t_mid r_m3;
    bpc_pkg::t_mid r_m4;
    logic [31:0]   r_sq;
    logic [31:0]   sq;
    logic [31:0]   r_pb2;
    logic [31:0]   r_pac2;
    logic [31:0]   r_pac3;
    logic [31:0]   r_pb1;
    logic [31:0]   x3;
    logic [31:0]   x3b;
    logic [31:0]   r_b3;
    logic [31:0]   r_x3b;
    logic [31:0]   r_b4;
    logic [31:0]   r_b7;
    bpc_pkg::t_ctx dctx;
    logic          q_vld;
    logic [31:0]   q;
    bpc_pkg::t_ctx q_ctx;
    logic [31:0]   p;
    logic [31:0]   p8;
    logic [2:0]    r_vld_t;
    logic [31:0]   r_p6;
    logic [31:0]   r_x1s;
    logic [31:0]   r_x2;
    bpc_pkg::t_ctx r_c6;
    logic [31:0]   r_p7;
    logic [31:0]   r_x1;
    logic [31:0]   r_x27;
    bpc_pkg::t_ctx r_c7;
    bpc_pkg::t_out r_out;
    logic [31:0]   pf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_vld_t <= '0;
        end else begin
            r_vld   <= {r_vld[2:0], i_vld};
            r_vld_t <= {r_vld_t[1:0], q_vld};
        end
    end

    assign sq  = bpc_pkg::asr32(r_sq, 5'd12);
    assign x3  = bpc_pkg::asr32(r_pb2, 5'd11) + bpc_pkg::asr32(r_pac2, 5'd11);
    assign x3b = bpc_pkg::asr32(bpc_pkg::asr32(r_pac3, 5'd13)
                 + bpc_pkg::asr32(r_pb1, 5'd16) + 32'd2, 5'd2);

    always_ff @(posedge i_clk) begin
        r_m1   <= i_mid;
        r_sq   <= i_mid.b6 * i_mid.b6;
        r_m2   <= r_m1;
        r_pb2  <= i_cal.b2 * sq;
        r_pac2 <= i_cal.ac2 * r_m1.b6;
        r_pac3 <= i_cal.ac3 * r_m1.b6;
        r_pb1  <= i_cal.b1 * sq;
        r_m3   <= r_m2;
        r_b3   <= bpc_pkg::asr32((((i_cal.ac1 << 2) + x3) << i_cal.oss) + 32'd2, 5'd2);
        r_x3b  <= x3b;
        r_m4   <= r_m3;
        r_b4   <= (i_cal.ac4 * (r_x3b + bpc_pkg::K_B4_OFS)) >> 15;
        r_b7   <= (r_m3.up - r_b3) * (bpc_pkg::K_B7_SCALE >> i_cal.oss);
    end

    always_comb begin
        dctx       = '0;
        dctx.fault = r_m4.fault | (r_b4 == 32'd0);
        dctx.dbl   = r_b7[31];
        dctx.temp  = r_m4.temp;
    end

    bpc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (r_vld[3]),
        .i_dividend (r_b7[31] ? r_b7 : {r_b7[30:0], 1'b0}),
        .i_divisor  (r_b4),
        .i_ctx      (dctx),
        .o_vld      (q_vld),
        .o_quo      (q),
        .o_ctx      (q_ctx)
    );

    assign p  = q_ctx.dbl ? {q[30:0], 1'b0} : q;
    assign p8 = bpc_pkg::asr32(p, 5'd8);
    assign pf = r_p7 + bpc_pkg::asr32(r_x1 + r_x27 + bpc_pkg::K_P_OFS, 5'd4);

    always_ff @(posedge i_clk) begin
        r_p6  <= p;
        r_x1s <= p8 * p8;
        r_x2  <= bpc_pkg::asr32(bpc_pkg::K_P_LIN * p, 5'd16);
        r_c6  <= q_ctx;
        r_p7  <= r_p6;
        r_x1  <= bpc_pkg::asr32(r_x1s * bpc_pkg::K_P_SQ, 5'd16);
        r_x27 <= r_x2;
        r_c7  <= r_c6;
        r_out.divide_fault       <= r_c7.fault;
        r_out.temperature_tenths <= r_c7.fault ? '0 : r_c7.temp;
        r_out.pressure_pa        <= r_c7.fault ? '0 : pf;
    end

    assign o_vld = r_vld_t[2];
    assign o_out = r_out;

endmodule

[src/barometer_pressure_compensation.sv]
// channel   direction  ports                           word
// start     in         start, busy, i_in               raw temperature and pressure
// result    out        o_done, o_out                   tenths of a degree, pascals, fault
// config    in         i_cfg_we, i_cfg_idx, i_cfg_data one calibration register
// a word is taken every cycle; busy never rises
// each word passes through two 32-step pipelined dividers plus the
// multiply stages around them
// synchronous active-low reset clears valid bits and calibration registers
// the receiver cannot stall; o_done marks each result for one cycle
module barometer_pressure_compensation (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  bpc_pkg::t_in  i_in,
    output logic          o_done,
    output bpc_pkg::t_out o_out,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [63:0]   i_cfg_data
);

    logic [63:0]   r_cal_a;
    logic [63:0]   r_cal_b;
    logic [31:0]   r_cal_c;
    logic [1:0]    r_oss;
    bpc_pkg::t_cal cal;
    logic          mid_vld;
    bpc_pkg::t_mid mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_a <= '0;
            r_cal_b <= '0;
            r_cal_c <= '0;
            r_oss   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bpc_pkg::REG_CAL_A: r_cal_a <= i_cfg_data;
                bpc_pkg::REG_CAL_B: r_cal_b <= i_cfg_data;
                bpc_pkg::REG_CAL_C: r_cal_c <= i_cfg_data[31:0];
                bpc_pkg::REG_OSS:   r_oss   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign cal.ac1 = bpc_pkg::sx16(r_cal_a[63:48]);
    assign cal.ac2 = bpc_pkg::sx16(r_cal_a[47:32]);
    assign cal.ac3 = bpc_pkg::sx16(r_cal_a[31:16]);
    assign cal.ac4 = {16'd0, r_cal_a[15:0]};
    assign cal.ac5 = {16'd0, r_cal_b[63:48]};
    assign cal.ac6 = {16'd0, r_cal_b[47:32]};
    assign cal.b1  = bpc_pkg::sx16(r_cal_b[31:16]);
    assign cal.b2  = bpc_pkg::sx16(r_cal_b[15:0]);
    assign cal.mc  = bpc_pkg::sx16(r_cal_c[31:16]);
    assign cal.md  = bpc_pkg::sx16(r_cal_c[15:0]);
    assign cal.oss = r_oss;

    assign busy = 1'b0;

    bpc_temp u_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start & ~busy),
        .i_in    (i_in),
        .i_cal   (cal),
        .o_vld   (mid_vld),
        .o_mid   (mid)
    );

    bpc_press u_press (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (mid_vld),
        .i_mid   (mid),
        .i_cal   (cal),
        .o_vld   (o_done),
        .o_out   (o_out)
    );

`ifndef ASSERT_OFF
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_out.divide_fault |->
            o_out.temperature_tenths == 0 && o_out.pressure_pa == 0)
        else $error("fault result not zeroed");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##(bpc_pkg::LATENCY) o_done)
        else $error("result missing");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_done) |-> $past(start, bpc_pkg::LATENCY))
        else $error("result without word");
`endif

endmodule
